[hw/rtl/nst_pkg.sv]
`timescale 1ns / 1ps

package nst_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 16;
	localparam int LEVEL_W     = 8;
	localparam int OUT_SLOT_W  = 6;
	localparam int OUT_CNT_W   = 7;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                      key_nz;
		logic [ADDR_W-1:0]         key;
		logic [CNT_W-1:0]          count;
		logic                      wr_en;
		logic [SLOT_W-1:0]         wr_slot;
		logic [ADDR_W-1:0]         wr_addr;
		logic signed [LEVEL_W-1:0] wr_level;
		logic                      shift_en;
		logic [SLOT_W-1:0]         shift_from;
	} cell_ctl_t;

	// search token, walks from the newest slot toward slot 0
	typedef struct packed {
		logic                      hit;
		logic signed [LEVEL_W-1:0] level;
		logic [SLOT_W-1:0]         slot;
	} tok_t;

endpackage

[hw/rtl/node_signal_table_unit.sv]
`timescale 1ns / 1ps

// Ordered table of (node address, signal level) pairs, oldest in slot 0.
// Request channel: in_valid/in_ready with req_type, node_id, signal_level.
// Result channel: out_valid/out_ready with found, found_level, found_slot,
// entry_count. Every request gives exactly one result.
// The table is a chain of TABLE_DEPTH cells. Add and clear skip the search
// and go from accept straight to the apply step. Lookup and delete send a
// search token from the newest cell down to cell 0, one cell per cycle, and
// the length of that token walk sets how long they take.
// One request is worked on at a time; the next one is accepted in the cycle
// after the previous result is registered, even if that result still waits.
// Reset clears the entry count and the handshake state; entry contents are
// not cleared and are never read above the count.
// If the receiver stalls, a finished result is held in the output register;
// a following request can still be accepted and searched, and it holds in
// its final step until the output register is free.
module node_signal_table_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            req_type,
	input  logic [15:0]           node_id,
	input  logic signed [7:0]     signal_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic signed [7:0]     found_level,
	output logic [5:0]            found_slot,
	output logic [6:0]            entry_count
);

	localparam int DEPTH = nst_pkg::TABLE_DEPTH;

	nst_pkg::state_t                    state_q, state_nxt;
	nst_pkg::req_t                      req_q;
	logic [nst_pkg::ADDR_W-1:0]         key_q;
	logic signed [nst_pkg::LEVEL_W-1:0] lvl_q;
	logic [nst_pkg::CNT_W-1:0]          count_q, count_nxt;
	logic [nst_pkg::SLOT_W-1:0]         cnt_q;
	logic                               accept;
	logic                               apply_go;
	logic                               search_done;
	logic                               full;
	nst_pkg::cell_ctl_t                 ctl;

	logic                               out_valid_q;
	logic                               found_q;
	logic signed [7:0]                  found_level_q;
	logic [5:0]                         found_slot_q;
	logic [6:0]                         entry_count_q;

	logic [nst_pkg::ADDR_W-1:0]         cell_addr  [DEPTH+1];
	logic signed [nst_pkg::LEVEL_W-1:0] cell_level [DEPTH+1];
	nst_pkg::tok_t                      tok        [DEPTH+1];
	nst_pkg::tok_t                      res_tok;

	assign accept      = in_valid && in_ready;
	assign full        = (count_q == nst_pkg::CNT_W'(DEPTH));
	assign search_done = (cnt_q == nst_pkg::SLOT_W'(DEPTH - 1));
	assign apply_go    = (state_q == nst_pkg::ST_APPLY) && (!out_valid_q || out_ready);
	assign res_tok     = tok[0];

	// ---- next state ----
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			nst_pkg::ST_IDLE: begin
				if (in_valid) begin
					if ((nst_pkg::req_t'(req_type) == nst_pkg::REQ_LOOKUP) ||
					    (nst_pkg::req_t'(req_type) == nst_pkg::REQ_DELETE)) begin
						state_nxt = nst_pkg::ST_SEARCH;
					end else begin
						state_nxt = nst_pkg::ST_APPLY;
					end
				end
			end
			nst_pkg::ST_SEARCH: begin
				if (search_done) begin
					state_nxt = nst_pkg::ST_APPLY;
				end
			end
			nst_pkg::ST_APPLY: begin
				if (apply_go) begin
					state_nxt = nst_pkg::ST_IDLE;
				end
			end
			default: state_nxt = nst_pkg::ST_IDLE;
		endcase
	end

	// ---- outputs: handshake and cell control ----
	always_comb begin
		in_ready       = 1'b0;
		ctl.key_nz     = (key_q != '0);
		ctl.key        = key_q;
		ctl.count      = count_q;
		ctl.wr_en      = 1'b0;
		ctl.wr_slot    = full ? nst_pkg::SLOT_W'(DEPTH - 1) : nst_pkg::SLOT_W'(count_q);
		ctl.wr_addr    = key_q;
		ctl.wr_level   = lvl_q;
		ctl.shift_en   = 1'b0;
		ctl.shift_from = '0;
		count_nxt      = count_q;
		case (state_q)
			nst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			nst_pkg::ST_SEARCH: begin
				in_ready = 1'b0;
			end
			nst_pkg::ST_APPLY: begin
				if (apply_go) begin
					case (req_q)
						nst_pkg::REQ_ADD: begin
							// full table: drop slot 0, shift all down, new pair on top
							ctl.wr_en    = 1'b1;
							ctl.shift_en = full;
							if (!full) begin
								count_nxt = count_q + 1'b1;
							end
						end
						nst_pkg::REQ_DELETE: begin
							if (res_tok.hit) begin
								ctl.shift_en   = 1'b1;
								ctl.shift_from = res_tok.slot;
								count_nxt      = count_q - 1'b1;
							end
						end
						nst_pkg::REQ_CLEAR: begin
							count_nxt = '0;
						end
						default: begin
							count_nxt = count_q;
						end
					endcase
				end
			end
			default: in_ready = 1'b0;
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nst_pkg::ST_IDLE;
			count_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (state_q == nst_pkg::ST_SEARCH) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// request fields held for the whole search
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= nst_pkg::req_t'(req_type);
			key_q <= node_id;
			lvl_q <= signal_level;
		end
	end

	// ---- cell chain ----
	assign cell_addr[DEPTH]  = key_q;
	assign cell_level[DEPTH] = lvl_q;
	assign tok[DEPTH]        = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		nst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.my_slot   (nst_pkg::SLOT_W'(i)),
			.nbr_addr  (cell_addr[i+1]),
			.nbr_level (cell_level[i+1]),
			.addr      (cell_addr[i]),
			.level     (cell_level[i]),
			.tok_in    (tok[i+1]),
			.tok_out   (tok[i])
		);
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			entry_count_q <= nst_pkg::OUT_CNT_W'(count_nxt);
			if ((req_q == nst_pkg::REQ_LOOKUP) || (req_q == nst_pkg::REQ_DELETE)) begin
				// a token without a hit carries all zeros
				found_q       <= res_tok.hit;
				found_level_q <= res_tok.level;
				found_slot_q  <= nst_pkg::OUT_SLOT_W'(res_tok.slot);
			end else begin
				found_q       <= 1'b0;
				found_level_q <= '0;
				found_slot_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign found_level = found_level_q;
	assign found_slot  = found_slot_q;
	assign entry_count = entry_count_q;

endmodule

[hw/rtl/nst_cell.sv]
`timescale 1ns / 1ps

module nst_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nst_pkg::cell_ctl_t                 ctl,
	input  logic [nst_pkg::SLOT_W-1:0]         my_slot,
	input  logic [nst_pkg::ADDR_W-1:0]         nbr_addr,
	input  logic signed [nst_pkg::LEVEL_W-1:0] nbr_level,
	output logic [nst_pkg::ADDR_W-1:0]         addr,
	output logic signed [nst_pkg::LEVEL_W-1:0] level,
	input  nst_pkg::tok_t                      tok_in,
	output nst_pkg::tok_t                      tok_out
);

	logic [nst_pkg::ADDR_W-1:0]         addr_q;
	logic signed [nst_pkg::LEVEL_W-1:0] level_q;
	logic                               tok_hit_q;
	logic signed [nst_pkg::LEVEL_W-1:0] tok_level_q;
	logic [nst_pkg::SLOT_W-1:0]         tok_slot_q;
	logic                               occupied;
	logic                               match;

	assign occupied = nst_pkg::CNT_W'(my_slot) < ctl.count;
	assign match    = ctl.key_nz && occupied && (addr_q == ctl.key);

	// entry storage: new write wins over a shift from the neighbor above
	always_ff @(posedge clk) begin
		if (ctl.wr_en && (ctl.wr_slot == my_slot)) begin
			addr_q  <= ctl.wr_addr;
			level_q <= ctl.wr_level;
		end else if (ctl.shift_en && (my_slot >= ctl.shift_from)) begin
			addr_q  <= nbr_addr;
			level_q <= nbr_level;
		end
	end

	// first match seen by the token (coming from above) is the newest one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_hit_q <= 1'b0;
		end else begin
			tok_hit_q <= tok_in.hit || match;
		end
	end

	always_ff @(posedge clk) begin
		if (!tok_in.hit && match) begin
			tok_level_q <= level_q;
			tok_slot_q  <= my_slot;
		end else begin
			tok_level_q <= tok_in.level;
			tok_slot_q  <= tok_in.slot;
		end
	end

	assign addr          = addr_q;
	assign level         = level_q;
	assign tok_out.hit   = tok_hit_q;
	assign tok_out.level = tok_level_q;
	assign tok_out.slot  = tok_slot_q;

endmodule

[sim/node_signal_table_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of node_signal_table_unit, keeps a shadow copy of the
// table, and compares every result against the answer it predicts.
module node_signal_table_checker
	import nst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                req_type,
	input  logic [ADDR_W-1:0]         node_id,
	input  logic signed [LEVEL_W-1:0] signal_level,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      found,
	input  logic signed [LEVEL_W-1:0] found_level,
	input  logic [OUT_SLOT_W-1:0]     found_slot,
	input  logic [OUT_CNT_W-1:0]      entry_count,
	output int                        mismatches,
	output int                        pending,
	output int                        results_checked,
	output int                        hits_seen,
	output int                        oldest_drops
);

	typedef struct packed {
		logic                      hit;
		logic signed [LEVEL_W-1:0] level;
		logic [OUT_SLOT_W-1:0]     slot;
		logic [OUT_CNT_W-1:0]      count;
	} table_answer_t;

	logic [ADDR_W-1:0]         shadow_addr [TABLE_DEPTH];
	logic signed [LEVEL_W-1:0] shadow_level [TABLE_DEPTH];
	int                        shadow_count = 0;
	table_answer_t             answers_due [$];

	initial begin
		mismatches      = 0;
		pending         = 0;
		results_checked = 0;
		hits_seen       = 0;
		oldest_drops    = 0;
	end

	// newest valid slot holding id, -1 if none; address zero never matches
	function automatic int newest_slot(input logic [ADDR_W-1:0] id);
		int i;
		if (id == '0)
			return -1;
		for (i = shadow_count - 1; i >= 0; i--) begin
			if (shadow_addr[i] == id)
				return i;
		end
		return -1;
	endfunction

	function automatic void close_gap(input int slot);
		int i;
		shadow_count--;
		for (i = slot; i < shadow_count; i++) begin
			shadow_addr[i]  = shadow_addr[i + 1];
			shadow_level[i] = shadow_level[i + 1];
		end
	endfunction

	// applies one request to the shadow table and returns its answer
	function automatic table_answer_t apply_request(input req_t kind,
			input logic [ADDR_W-1:0] id, input logic signed [LEVEL_W-1:0] lvl);
		table_answer_t ans;
		int            slot;
		ans  = '0;
		slot = -1;
		case (kind)
			REQ_ADD: begin
				if (shadow_count >= TABLE_DEPTH) begin
					close_gap(0);
					oldest_drops++;
				end
				shadow_addr[shadow_count]  = id;
				shadow_level[shadow_count] = lvl;
				shadow_count++;
			end
			REQ_LOOKUP, REQ_DELETE: begin
				slot = newest_slot(id);
				if (slot >= 0) begin
					ans.hit   = 1'b1;
					ans.level = shadow_level[slot];
					ans.slot  = OUT_SLOT_W'(slot);
					if (kind == REQ_DELETE)
						close_gap(slot);
				end
			end
			default: shadow_count = 0;
		endcase
		ans.count = OUT_CNT_W'(shadow_count);
		return ans;
	endfunction

	task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected 0x%h, got 0x%h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		table_answer_t want;
		if (arst_n) begin
			// result side first: a request accepted now cannot be answered now
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no request waiting, expected none, got found=%b slot=%0d count=%0d",
						$time, found, found_slot, entry_count);
				end else begin
					want = answers_due.pop_front();
					compare_field("found", ADDR_W'(want.hit), ADDR_W'(found));
					compare_field("found_level", ADDR_W'(want.level), ADDR_W'(found_level));
					compare_field("found_slot", ADDR_W'(want.slot), ADDR_W'(found_slot));
					compare_field("entry_count", ADDR_W'(want.count), ADDR_W'(entry_count));
					results_checked++;
					if (want.hit)
						hits_seen++;
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(apply_request(req_t'(req_type), node_id, signal_level));
			pending = answers_due.size();
		end
	end

endmodule

[sim/tb_node_signal_table_unit.sv]
`timescale 1ns / 1ps

// Top of the node_signal_table_unit bench. It only drives requests and the
// result-side ready, and gives the verdict; the checker beside the block
// predicts and compares every result.
module tb_node_signal_table_unit;
	import nst_pkg::*;

	localparam int CLK_HALF_NS    = 6;
	localparam int RANDOM_ITEMS   = 500;
	localparam int IDLE_PCT       = 8;
	localparam int MIXED_BURST    = 40;
	localparam int ID_POOL_SIZE   = 12;
	// receiver hold-off, long enough for the block to fill and stall its input
	localparam int RX_HOLD_CYCLES = 300;
	// slowest request is a search down the whole cell chain; allow for the
	// hold-off and random stalls many times over
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	logic [1:0]                req_type     = REQ_CLEAR;
	logic [ADDR_W-1:0]         node_id      = '0;
	logic signed [LEVEL_W-1:0] signal_level = '0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic                      found;
	logic signed [LEVEL_W-1:0] found_level;
	logic [OUT_SLOT_W-1:0]     found_slot;
	logic [OUT_CNT_W-1:0]      entry_count;

	int mismatches;
	int pending;
	int results_checked;
	int hits_seen;
	int oldest_drops;

	// shared knobs: random idling on/off, and the one-time receiver hold-off
	logic idle_on       = 1'b1;
	logic rx_hold_asked = 1'b0;
	logic rx_hold_done  = 1'b0;

	int                requests_sent [4] = '{0, 0, 0, 0};
	int                quiet_cycles      = 0;
	logic [ADDR_W-1:0] id_pool [ID_POOL_SIZE];

	node_signal_table_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.node_id      (node_id),
		.signal_level (signal_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.found_level  (found_level),
		.found_slot   (found_slot),
		.entry_count  (entry_count)
	);

	node_signal_table_checker table_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.node_id         (node_id),
		.signal_level    (signal_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.found_level     (found_level),
		.found_slot      (found_slot),
		.entry_count     (entry_count),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.hits_seen       (hits_seen),
		.oldest_drops    (oldest_drops)
	);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// One request: optional idle cycles with valid low, then hold valid and
	// payload steady until the block takes it. Valid stays high on return so
	// back-to-back requests never drop it within a step.
	task automatic send_req(input req_t kind, input logic [ADDR_W-1:0] id,
			input logic [LEVEL_W-1:0] lvl);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		node_id      <= id;
		signal_level <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent[int'(kind)]++;
	endtask

	// mostly addresses from a small pool so lookups and deletes hit and
	// duplicates pile up; some zero, some fully random
	function automatic logic [ADDR_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
		else if (r < 88)
			return '0;
		return ADDR_W'($urandom);
	endfunction

	// Result side: random ready, with one long hold-off counted here while
	// the sender keeps offering requests.
	initial begin : result_side
		forever begin
			@(posedge clk);
			if (rx_hold_asked && !rx_hold_done) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES)
					@(posedge clk);
				rx_hold_done = 1'b1;
			end
			out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog: cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int                 round;
		int                 n_random;
		int                 burst;
		int                 r;
		int                 i;
		logic [LEVEL_W-1:0] lvl;
		req_t               kind;

		for (i = 0; i < ID_POOL_SIZE; i++)
			id_pool[i] = ADDR_W'($urandom);
		id_pool[0] = 16'hFFFF;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, address zero, extremes, duplicates, gap
		// closing, clear leaving stale slots behind
		send_req(REQ_LOOKUP, 16'h1234, 8'h00);   // lookup on empty table
		send_req(REQ_DELETE, 16'h1234, 8'h00);   // delete on empty table
		send_req(REQ_CLEAR,  16'hFFFF, 8'h7F);   // clear when already empty
		send_req(REQ_ADD,    16'h0000, 8'h80);   // zero address can be stored
		send_req(REQ_ADD,    16'hFFFF, 8'h7F);
		send_req(REQ_ADD,    16'h0001, 8'h00);
		send_req(REQ_ADD,    16'hFFFF, 8'hFF);   // duplicate, newest wins
		send_req(REQ_LOOKUP, 16'h0000, 8'h00);   // zero never matches
		send_req(REQ_DELETE, 16'h0000, 8'h00);
		send_req(REQ_LOOKUP, 16'hFFFF, 8'h00);   // newest copy in slot 3
		send_req(REQ_DELETE, 16'hFFFF, 8'h00);   // removes the top slot
		send_req(REQ_DELETE, 16'hFFFF, 8'h00);   // removes slot 1, shifts down
		send_req(REQ_LOOKUP, 16'h0001, 8'h00);   // moved into slot 1
		send_req(REQ_LOOKUP, 16'hFFFF, 8'h00);   // gone now
		send_req(REQ_ADD,    16'hA5A5, 8'h5A);
		send_req(REQ_CLEAR,  16'h0000, 8'h00);
		send_req(REQ_LOOKUP, 16'h0001, 8'h00);   // stale slot must not match
		send_req(REQ_LOOKUP, 16'hA5A5, 8'h00);

		// random rounds: every third one overfills the table to force
		// oldest-entry drops, the others mix all four requests
		n_random = 0;
		round    = 0;
		while (n_random < RANDOM_ITEMS) begin
			idle_on = (round != 1);   // round 1 runs with no idling at all
			if (round == 2)
				rx_hold_asked = 1'b1;
			for (i = 0; i < 3; i++)
				id_pool[$urandom_range(1, ID_POOL_SIZE - 1)] = ADDR_W'($urandom);

			if (round % 3 == 0) begin
				burst = TABLE_DEPTH + $urandom_range(2, 12);
				repeat (burst) begin
					lvl = LEVEL_W'($urandom_range(0, 255));
					send_req(REQ_ADD, pick_id(), lvl);
				end
			end else begin
				burst = MIXED_BURST;
				repeat (burst) begin
					r = $urandom_range(0, 99);
					if (r < 35)
						kind = REQ_ADD;
					else if (r < 70)
						kind = REQ_LOOKUP;
					else if (r < 95)
						kind = REQ_DELETE;
					else
						kind = REQ_CLEAR;
					lvl = LEVEL_W'($urandom_range(0, 255));
					send_req(kind, pick_id(), lvl);
				end
			end
			n_random += burst;
			round++;
		end
		in_valid <= 1'b0;
		idle_on   = 1'b1;

		// let the checker see the last request, drain, then sit out a full
		// search time to catch any stray result
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Requests: %0d add, %0d lookup, %0d delete, %0d clear; receiver hold-off %s.",
			requests_sent[REQ_ADD], requests_sent[REQ_LOOKUP], requests_sent[REQ_DELETE],
			requests_sent[REQ_CLEAR], rx_hold_done ? "done" : "missed");
		$display("Results checked: %0d, matches: %0d, oldest entries dropped: %0d.",
			results_checked, hits_seen, oldest_drops);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
